/* sv/spr_pkg.sv */
package spr_pkg;

    localparam int SCORE_BITS      = 32;
    localparam int FRAC_BITS       = SCORE_BITS - 1;
    localparam int DVD_W           = SCORE_BITS + 2;
    localparam int MAX_NODES_DEF   = 1024;
    localparam int MAX_ENTRIES_DEF = 4096;
    localparam int NODE_FIELD_W    = 10;

    localparam logic [SCORE_BITS-1:0] SCORE_MAX = {SCORE_BITS{1'b1}};
    localparam logic [SCORE_BITS-1:0] Q_ONE     = SCORE_BITS'(1) << FRAC_BITS;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_RUN   = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [1:0] CFG_DAMPING    = 2'd1;
    localparam logic [1:0] CFG_TOLERANCE  = 2'd2;
    localparam logic [1:0] CFG_MAX_ITER   = 2'd3;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_SCORE  = 1'b1;

    typedef struct packed {
        logic [1:0]              cmd;
        logic [NODE_FIELD_W-1:0] entry_row;
        logic [NODE_FIELD_W-1:0] entry_col;
        logic [SCORE_BITS-1:0]   entry_weight;
        logic [NODE_FIELD_W-1:0] read_node;
    } item_t;

    typedef struct packed {
        logic                  result_kind;
        logic [SCORE_BITS-1:0] score_value;
        logic [15:0]           iterations_done;
        logic [SCORE_BITS-1:0] final_difference;
        logic                  converged;
        logic                  error_flag;
    } result_t;

    typedef struct packed {
        logic [NODE_FIELD_W-1:0] row;
        logic [NODE_FIELD_W-1:0] col;
        logic [SCORE_BITS-1:0]   weight;
    } entry_t;

    typedef struct packed {
        logic clear;
        logic append;
        logic rd_en;
    } ent_ctl_t;

    // Clamp a wide nonnegative value to the largest score code.
    function automatic logic [SCORE_BITS-1:0] sat_score(input logic [DVD_W-1:0] v);
        logic [SCORE_BITS-1:0] r;
        begin
            r = (v > DVD_W'(SCORE_MAX)) ? SCORE_MAX : v[SCORE_BITS-1:0];
            return r;
        end
    endfunction

endpackage

/* sv/sparse_pagerank_power_iteration.sv */
// Channel  | Signals                        | Transfer
// ---------+--------------------------------+-------------------------------------
// command  | start, busy, item              | edge with start high and busy low
// result   | done, result                   | every cycle with done high
// config   | cfg_we, cfg_addr, cfg_data     | edge with cfg_we high, no wait
//
// Clear and load keep busy low. A read goes through the score memory read,
// then the result register that presents it. A run first seeds scores and
// rebuilds outlink marks, then iterates over the nodes and entries; an entry
// whose row or column lies outside the node count is skipped after its read,
// and each kept entry does a read-modify-write of its row sum.
// rst_n clears control state only; score memories hold nothing valid until a run.
// The result receiver cannot stall: done is high for exactly one cycle.
module sparse_pagerank_power_iteration #(
    parameter int MAX_NODES   = spr_pkg::MAX_NODES_DEF,
    parameter int MAX_ENTRIES = spr_pkg::MAX_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  spr_pkg::item_t                  item,
    output logic                            done,
    output spr_pkg::result_t                result,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_addr,
    input  logic [spr_pkg::SCORE_BITS-1:0]  cfg_data
);
    import spr_pkg::*;

    localparam int NAW = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int EAW = $clog2(MAX_ENTRIES);
    localparam int ECW = $clog2(MAX_ENTRIES + 1);
    localparam int SB  = SCORE_BITS;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_READ  = 5'd1;
    localparam logic [4:0] ST_DIV1  = 5'd2;
    localparam logic [4:0] ST_INIT  = 5'd3;
    localparam logic [4:0] ST_FADDR = 5'd4;
    localparam logic [4:0] ST_FDATA = 5'd5;
    localparam logic [4:0] ST_WADDR = 5'd6;
    localparam logic [4:0] ST_WDATA = 5'd7;
    localparam logic [4:0] ST_DW    = 5'd8;
    localparam logic [4:0] ST_TERM  = 5'd9;
    localparam logic [4:0] ST_DIV2  = 5'd10;
    localparam logic [4:0] ST_FILL  = 5'd11;
    localparam logic [4:0] ST_EADDR = 5'd12;
    localparam logic [4:0] ST_EDATA = 5'd13;
    localparam logic [4:0] ST_EPROD = 5'd14;
    localparam logic [4:0] ST_EACC  = 5'd15;
    localparam logic [4:0] ST_UADDR = 5'd16;
    localparam logic [4:0] ST_UDATA = 5'd17;
    localparam logic [4:0] ST_CHECK = 5'd18;

    // Configuration registers.
    logic [10:0]   node_count_reg;
    logic [SB-1:0] damping_reg;
    logic [SB-1:0] tolerance_reg;
    logic [15:0]   max_iter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= 11'd1;
            damping_reg    <= SB'(1825361101);
            tolerance_reg  <= SB'(2147);
            max_iter_reg   <= 16'd1000;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_NODE_COUNT: node_count_reg <= cfg_data[10:0];
                CFG_DAMPING:    damping_reg    <= cfg_data;
                CFG_TOLERANCE:  tolerance_reg  <= cfg_data;
                CFG_MAX_ITER:   max_iter_reg   <= cfg_data[15:0];
                default:        ;
            endcase
        end
    end

    // Effective node count and iteration cap.
    logic [NCW-1:0] n_eff;
    logic [15:0]    cap;

    always_comb
    begin
        if (node_count_reg == 11'd0)
            n_eff = NCW'(1);
        else if (32'(node_count_reg) > 32'(MAX_NODES))
            n_eff = NCW'(MAX_NODES);
        else
            n_eff = NCW'(node_count_reg);
        cap = (max_iter_reg == 16'd0) ? 16'd1 : max_iter_reg;
    end

    // Control and datapath registers.
    logic [4:0]     state_reg, state_next;
    logic [NCW-1:0] idx_reg, idx_next;
    logic [ECW-1:0] k_reg, k_next;
    logic [SB-1:0]  acc_reg, acc_next;
    logic [SB-1:0]  maxd_reg, maxd_next;
    logic [15:0]    iters_reg, iters_next;
    logic [15:0]    last_iter_reg, last_iter_next;
    logic [SB-1:0]  val_reg, val_next;
    logic [2*SB-1:0] mul_reg, mul_next;
    logic [NAW-1:0] row_reg, row_next;
    logic           done_reg, done_next;
    result_t        result_reg, result_next;

    // Memory ports.
    logic [SB-1:0]  score_mem [MAX_NODES];
    logic [SB-1:0]  next_mem  [MAX_NODES];
    logic           flag_mem  [MAX_NODES];
    logic [SB-1:0]  score_q, next_q;
    logic           flag_q;
    logic           score_we, score_re, next_we, next_re, flag_we, flag_re;
    logic [NAW-1:0] score_waddr, score_raddr, next_waddr, next_raddr;
    logic [NAW-1:0] flag_waddr, flag_raddr;
    logic [SB-1:0]  score_wdata, next_wdata;
    logic           flag_wdata;

    always_ff @(posedge clk)
    begin
        if (score_we)
            score_mem[score_waddr] <= score_wdata;
        if (score_re)
            score_q <= score_mem[score_raddr];
        if (next_we)
            next_mem[next_waddr] <= next_wdata;
        if (next_re)
            next_q <= next_mem[next_raddr];
        if (flag_we)
            flag_mem[flag_waddr] <= flag_wdata;
        if (flag_re)
            flag_q <= flag_mem[flag_raddr];
    end

    // Link store and shared divider.
    ent_ctl_t       ent_ctl;
    entry_t         ent_wr, ent_q;
    logic [ECW-1:0] ent_count;
    logic           ent_full;

    assign ent_wr.row    = item.entry_row;
    assign ent_wr.col    = item.entry_col;
    assign ent_wr.weight = item.entry_weight;

    spr_entry_store #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_entries (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ent_ctl),
        .wr_entry (ent_wr),
        .rd_addr  (k_reg[EAW-1:0]),
        .rd_entry (ent_q),
        .count    (ent_count),
        .full     (ent_full)
    );

    logic             div_start, div_done;
    logic [DVD_W-1:0] div_dvd;
    logic [SB-1:0]    div_q;

    spr_div #(
        .DIVISOR_W (NCW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (n_eff),
        .done     (div_done),
        .quotient (div_q)
    );

    // Shared multiplier; its product is always registered.
    logic [SB-1:0]   mul_a, mul_b;
    logic [2*SB-1:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic           load_bad, read_bad, ent_bad;
    logic [SB:0]    dw;
    logic [DVD_W-1:0] term;
    logic [SB-1:0]  diff;
    logic [15:0]    iters_inc;

    assign load_bad  = ent_full || (32'(item.entry_row) >= 32'(n_eff))
                    || (32'(item.entry_col) >= 32'(n_eff));
    assign read_bad  = 32'(item.read_node) >= 32'(n_eff);
    assign ent_bad   = (32'(ent_q.row) >= 32'(n_eff)) || (32'(ent_q.col) >= 32'(n_eff));
    assign dw        = mul_reg[2*SB-1:FRAC_BITS];
    assign diff      = (next_q > score_q) ? next_q - score_q : score_q - next_q;
    assign iters_inc = iters_reg + 16'd1;

    always_comb
    begin
        term = DVD_W'(Q_ONE) + DVD_W'(dw);
        term = (term > DVD_W'(damping_reg)) ? term - DVD_W'(damping_reg) : '0;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        acc_next       = acc_reg;
        maxd_next      = maxd_reg;
        iters_next     = iters_reg;
        last_iter_next = last_iter_reg;
        val_next       = val_reg;
        mul_next       = mul_reg;
        row_next       = row_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        ent_ctl        = '0;
        score_we = 1'b0; score_re = 1'b0; next_we = 1'b0;
        next_re  = 1'b0; flag_we  = 1'b0; flag_re = 1'b0;
        score_waddr = idx_reg[NAW-1:0];
        score_raddr = idx_reg[NAW-1:0];
        next_waddr  = idx_reg[NAW-1:0];
        next_raddr  = idx_reg[NAW-1:0];
        flag_waddr  = idx_reg[NAW-1:0];
        flag_raddr  = idx_reg[NAW-1:0];
        score_wdata = val_reg;
        next_wdata  = val_reg;
        flag_wdata  = 1'b0;
        div_start   = 1'b0;
        div_dvd     = DVD_W'(Q_ONE);
        mul_a       = damping_reg;
        mul_b       = acc_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (item.cmd)
                        CMD_CLEAR: ent_ctl.clear = 1'b1;
                        CMD_LOAD:
                        begin
                            if (load_bad)
                            begin
                                done_next   = 1'b1;
                                result_next = '{KIND_STATUS, '0, last_iter_reg, '0, 1'b0, 1'b1};
                            end
                            else
                                ent_ctl.append = 1'b1;
                        end
                        CMD_RUN:
                        begin
                            div_start  = 1'b1;
                            iters_next = '0;
                            state_next = ST_DIV1;
                        end
                        default:
                        begin
                            if (read_bad)
                            begin
                                done_next   = 1'b1;
                                result_next = '{KIND_SCORE, '0, last_iter_reg, '0, 1'b0, 1'b1};
                            end
                            else
                            begin
                                score_re    = 1'b1;
                                score_raddr = NAW'(item.read_node);
                                state_next  = ST_READ;
                            end
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                done_next   = 1'b1;
                result_next = '{KIND_SCORE, score_q, last_iter_reg, '0, 1'b0, 1'b0};
                state_next  = ST_IDLE;
            end
            ST_DIV1:
            begin
                if (div_done)
                begin
                    val_next   = div_q;
                    idx_next   = '0;
                    state_next = ST_INIT;
                end
            end
            // Seed every score at 1/N and drop all outlink marks.
            ST_INIT:
            begin
                if (idx_reg == n_eff)
                begin
                    k_next     = '0;
                    state_next = ST_FADDR;
                end
                else
                begin
                    score_we = 1'b1;
                    flag_we  = 1'b1;
                    idx_next = idx_reg + NCW'(1);
                end
            end
            // Rebuild outlink marks from the entries that fit the node count.
            ST_FADDR:
            begin
                if (k_reg == ent_count)
                begin
                    idx_next   = '0;
                    acc_next   = '0;
                    state_next = ST_WADDR;
                end
                else
                begin
                    ent_ctl.rd_en = 1'b1;
                    state_next    = ST_FDATA;
                end
            end
            ST_FDATA:
            begin
                if (!ent_bad)
                begin
                    flag_we    = 1'b1;
                    flag_waddr = NAW'(ent_q.col);
                    flag_wdata = 1'b1;
                end
                k_next     = k_reg + ECW'(1);
                state_next = ST_FADDR;
            end
            // Sum the dangling scores, saturating.
            ST_WADDR:
            begin
                if (idx_reg == n_eff)
                    state_next = ST_DW;
                else
                begin
                    score_re   = 1'b1;
                    flag_re    = 1'b1;
                    state_next = ST_WDATA;
                end
            end
            ST_WDATA:
            begin
                if (!flag_q)
                    acc_next = sat_score(DVD_W'(acc_reg) + DVD_W'(score_q));
                idx_next   = idx_reg + NCW'(1);
                state_next = ST_WADDR;
            end
            ST_DW:
            begin
                mul_next   = mul_p;
                state_next = ST_TERM;
            end
            ST_TERM:
            begin
                div_start  = 1'b1;
                div_dvd    = term;
                state_next = ST_DIV2;
            end
            ST_DIV2:
            begin
                if (div_done)
                begin
                    val_next   = div_q;
                    idx_next   = '0;
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (idx_reg == n_eff)
                begin
                    k_next     = '0;
                    state_next = ST_EADDR;
                end
                else
                begin
                    next_we  = 1'b1;
                    idx_next = idx_reg + NCW'(1);
                end
            end
            // Entry walk: one read-modify-write of a row sum at a time.
            ST_EADDR:
            begin
                if (k_reg == ent_count)
                begin
                    idx_next   = '0;
                    maxd_next  = '0;
                    state_next = ST_UADDR;
                end
                else
                begin
                    ent_ctl.rd_en = 1'b1;
                    state_next    = ST_EDATA;
                end
            end
            ST_EDATA:
            begin
                if (ent_bad)
                begin
                    k_next     = k_reg + ECW'(1);
                    state_next = ST_EADDR;
                end
                else
                begin
                    mul_b       = ent_q.weight;
                    mul_next    = mul_p;
                    score_re    = 1'b1;
                    score_raddr = NAW'(ent_q.col);
                    row_next    = NAW'(ent_q.row);
                    state_next  = ST_EPROD;
                end
            end
            ST_EPROD:
            begin
                mul_a      = sat_score(DVD_W'(dw));
                mul_b      = score_q;
                mul_next   = mul_p;
                next_re    = 1'b1;
                next_raddr = row_reg;
                state_next = ST_EACC;
            end
            ST_EACC:
            begin
                next_we    = 1'b1;
                next_waddr = row_reg;
                next_wdata = sat_score(DVD_W'(next_q) + DVD_W'(dw));
                k_next     = k_reg + ECW'(1);
                state_next = ST_EADDR;
            end
            // Commit new scores and track the largest change.
            ST_UADDR:
            begin
                if (idx_reg == n_eff)
                    state_next = ST_CHECK;
                else
                begin
                    score_re   = 1'b1;
                    next_re    = 1'b1;
                    state_next = ST_UDATA;
                end
            end
            ST_UDATA:
            begin
                if (diff > maxd_reg)
                    maxd_next = diff;
                score_we    = 1'b1;
                score_wdata = next_q;
                idx_next    = idx_reg + NCW'(1);
                state_next  = ST_UADDR;
            end
            ST_CHECK:
            begin
                iters_next = iters_inc;
                if ((maxd_reg > tolerance_reg) && (iters_inc < cap))
                begin
                    idx_next   = '0;
                    acc_next   = '0;
                    state_next = ST_WADDR;
                end
                else
                begin
                    last_iter_next = iters_inc;
                    done_next      = 1'b1;
                    result_next    = '{KIND_STATUS, '0, iters_inc, maxd_reg,
                                       maxd_reg <= tolerance_reg, 1'b0};
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            done_reg      <= 1'b0;
            last_iter_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            last_iter_reg <= last_iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        k_reg      <= k_next;
        acc_reg    <= acc_next;
        maxd_reg   <= maxd_next;
        iters_reg  <= iters_next;
        val_reg    <= val_next;
        mul_reg    <= mul_next;
        row_reg    <= row_next;
        result_reg <= result_next;
    end

    assign busy   = state_reg != ST_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

    // Every result closes out its command: the block is idle when it shows.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result shown while busy");

    assert property (@(posedge clk) disable iff (!rst_n) ent_count <= ECW'(MAX_ENTRIES))
        else $error("link store overfilled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.converged) |-> (result.result_kind == KIND_STATUS && !result.error_flag))
        else $error("converged flag on a non-run result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UDATA || state_reg == ST_WDATA) |-> idx_reg < n_eff)
        else $error("node sweep beyond node count");

endmodule

/* sv/spr_div.sv */
module spr_div #(
    parameter int DIVISOR_W = 11
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [spr_pkg::DVD_W-1:0]      dividend,
    input  logic [DIVISOR_W-1:0]           divisor,
    output logic                           done,
    output logic [spr_pkg::SCORE_BITS-1:0] quotient
);
    import spr_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DVD_W-1:0]     dq_reg, dq_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W:0]   rem_shift;
    logic                 fits;

    // One quotient bit per cycle while busy, restoring form.
    always_comb
    begin
        rem_shift = {rem_reg, dq_reg[DVD_W-1]};
        fits      = rem_shift >= {1'b0, divisor};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            dq_next   = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DIVISOR_W'(rem_shift - {1'b0, divisor})
                            : rem_shift[DIVISOR_W-1:0];
            dq_next  = {dq_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = sat_score(dq_reg);

endmodule

/* sv/spr_entry_store.sv */
module spr_entry_store #(
    parameter int MAX_ENTRIES = 4096
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  spr_pkg::ent_ctl_t                      ctl,
    input  spr_pkg::entry_t                        wr_entry,
    input  logic [$clog2(MAX_ENTRIES)-1:0]         rd_addr,
    output spr_pkg::entry_t                        rd_entry,
    output logic [$clog2(MAX_ENTRIES + 1)-1:0]     count,
    output logic                                   full
);
    import spr_pkg::*;

    localparam int EAW = $clog2(MAX_ENTRIES);
    localparam int ECW = $clog2(MAX_ENTRIES + 1);

    entry_t         mem [MAX_ENTRIES];
    entry_t         rd_reg;
    logic [ECW-1:0] count_reg, count_next;

    assign full = count_reg >= ECW'(MAX_ENTRIES);

    always_comb
    begin
        count_next = count_reg;
        if (ctl.clear)
            count_next = '0;
        else if (ctl.append && !full)
            count_next = count_reg + ECW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // Append at the fill level; the fill level bounds every later walk.
    always_ff @(posedge clk)
    begin
        if (ctl.append && !full)
            mem[count_reg[EAW-1:0]] <= wr_entry;
        if (ctl.rd_en)
            rd_reg <= mem[rd_addr];
    end

    assign rd_entry = rd_reg;
    assign count    = count_reg;

endmodule
